// ===== sv/med_pkg.sv =====
// Shared types and constants for the message envelope deframer.
// Holds header layout, error codes, the result record and the magic byte table.
// Has no dependencies.
package med_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int HPOS_W       = $clog2(HEADER_BYTES + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]        VERSION_RESET = 8'd2;
   localparam logic [HPOS_W-1:0] POS_VERSION   = HPOS_W'(4);
   localparam logic [HPOS_W-1:0] POS_TYPE      = HPOS_W'(5);
   localparam logic [HPOS_W-1:0] POS_LENGTH    = HPOS_W'(8);
   localparam logic [HPOS_W-1:0] POS_DONE      = HPOS_W'(HEADER_BYTES);

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_SHORT   = 3'd1,
      ERR_MAGIC   = 3'd2,
      ERR_VERSION = 3'd3,
      ERR_LENGTH  = 3'd4
   } err_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        last;
      logic [7:0]  payload_byte;
      logic        accepted;
      err_type     error_code;
      logic [7:0]  message_kind;
      logic [15:0] header_flags;
      logic [31:0] declared_length;
   } result_type;

   // Magic bytes 'U', 'B', 'N', '2' in arrival order.
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] value;
      unique case (idx)
         2'd0:    value = 8'h55;
         2'd1:    value = 8'h42;
         2'd2:    value = 8'h4E;
         default: value = 8'h32;
      endcase
      return value;
   endfunction

endpackage

// ===== sv/message_envelope_deframer.sv =====
// Message envelope deframer: header check, payload pass-through and verdict.
// Depends on med_pkg for header layout, error codes and the result record.
// A byte's results are written into the result queue at its transfer and offered on rsp from the queue head.
// Throughput: one byte per cycle; a final payload byte causes two results, which a
// four-entry result queue absorbs, and req_tready is low while it holds more than two.
// Reset clears the message state, empties the queue and sets the expected version to 2.
module message_envelope_deframer
   import med_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration: expected version byte.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   // Input bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // final_byte
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // payload_byte[7:0], accepted[8], error_code[11:9], message_kind[19:12],
   // header_flags[35:20], declared_length[67:36], zero fill[71:68]
   output logic [71:0] rsp_tdata,
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last
);

   logic [7:0]        version_ff;
   logic [HPOS_W-1:0] hdr_pos_ff, hdr_pos_in, hdr_pos_step;
   logic [31:0]       seen_ff, seen_in, seen_step;
   logic [31:0]       len_ff, len_in, len_step;
   logic [7:0]        type_ff, type_in, type_step;
   logic [15:0]       flags_ff, flags_in, flags_step;
   err_type           err_ff, err_in, err_step, byte_err, final_err;

   result_type              queue_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic [QIDX_W-1:0]       verdict_idx;

   logic       req_fire, rsp_fire, hdr_done, emit_payload, emit_verdict;
   logic [7:0] in_byte;
   result_type pay_res, ver_res, head;

   assign in_byte    = req_tdata;
   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign hdr_done   = (hdr_pos_ff == POS_DONE);

   // One byte's effect on the message state.
   always_comb begin
      hdr_pos_step = hdr_pos_ff;
      seen_step    = seen_ff;
      len_step     = len_ff;
      type_step    = type_ff;
      flags_step   = flags_ff;
      byte_err     = ERR_NONE;
      emit_payload = 1'b0;
      if (!hdr_done) begin
         hdr_pos_step = hdr_pos_ff + HPOS_W'(1);
         if (hdr_pos_ff < POS_VERSION) begin
            if (in_byte != magic_byte(hdr_pos_ff[1:0])) byte_err = ERR_MAGIC;
         end else if (hdr_pos_ff == POS_VERSION) begin
            if (in_byte != version_ff) byte_err = ERR_VERSION;
         end else if (hdr_pos_ff == POS_TYPE) begin
            type_step = in_byte;
         end else if (hdr_pos_ff < POS_LENGTH) begin
            flags_step = {flags_ff[7:0], in_byte};
         end else begin
            len_step = {len_ff[23:0], in_byte};
         end
      end else begin
         if (seen_ff >= len_ff) begin
            byte_err = ERR_LENGTH;
         end else if (err_ff == ERR_NONE) begin
            emit_payload = 1'b1;
         end
         if (seen_ff != '1) seen_step = seen_ff + 32'd1;
      end
      err_step = (err_ff != ERR_NONE) ? err_ff : byte_err;

      // The verdict looks at the state after this byte has been counted.
      final_err = err_step;
      if (err_step == ERR_NONE) begin
         if (hdr_pos_step != POS_DONE) begin
            final_err = ERR_SHORT;
         end else if (seen_step != len_step) begin
            final_err = ERR_LENGTH;
         end
      end
   end

   assign emit_verdict = req_tlast;

   always_comb begin
      pay_res              = '0;
      pay_res.kind         = KIND_PAYLOAD;
      pay_res.payload_byte = in_byte;
      pay_res.last         = !req_tlast;
      pay_res.error_code   = ERR_NONE;

      ver_res                 = '0;
      ver_res.kind            = KIND_VERDICT;
      ver_res.last            = 1'b1;
      ver_res.accepted        = (final_err == ERR_NONE);
      ver_res.error_code      = final_err;
      ver_res.message_kind    = type_step;
      ver_res.header_flags    = flags_step;
      ver_res.declared_length = len_step;
   end

   // State update; a final byte returns everything to the start of a message.
   always_comb begin
      hdr_pos_in = hdr_pos_ff;
      seen_in    = seen_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      flags_in   = flags_ff;
      err_in     = err_ff;
      if (req_fire) begin
         if (req_tlast) begin
            hdr_pos_in = '0;
            seen_in    = '0;
            len_in     = '0;
            type_in    = '0;
            flags_in   = '0;
            err_in     = ERR_NONE;
         end else begin
            hdr_pos_in = hdr_pos_step;
            seen_in    = seen_step;
            len_in     = len_step;
            type_in    = type_step;
            flags_in   = flags_step;
            err_in     = err_step;
         end
      end
   end

   assign verdict_idx = emit_payload ? (wr_ptr_ff + QIDX_W'(1)) : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + QIDX_W'(emit_payload) + QIDX_W'(emit_verdict);
         count_in  = count_in + QCNT_W'(emit_payload) + QCNT_W'(emit_verdict);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + QIDX_W'(1);
         count_in  = count_in - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
         hdr_pos_ff <= '0;
         seen_ff    <= '0;
         len_ff     <= '0;
         type_ff    <= '0;
         flags_ff   <= '0;
         err_ff     <= ERR_NONE;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) version_ff <= csr_data;
         hdr_pos_ff <= hdr_pos_in;
         seen_ff    <= seen_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
         flags_ff   <= flags_in;
         err_ff     <= err_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit_payload) queue_ff[wr_ptr_ff] <= pay_res;
      if (req_fire && emit_verdict) queue_ff[verdict_idx] <= ver_res;
   end

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {4'b0000, head.declared_length, head.header_flags,
                       head.message_kind, head.error_code, head.accepted,
                       head.payload_byte};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count exceeds its depth");

   a_hdr_bound: assert property (@(posedge clock) disable iff (reset)
      hdr_pos_ff <= POS_DONE)
      else $error("header position ran past the header");

   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (hdr_pos_ff == '0 && seen_ff == '0 &&
                                   err_ff == ERR_NONE))
      else $error("message state not cleared after the final byte");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE && !(req_fire && req_tlast)) |=> $stable(err_ff))
      else $error("first error changed before the verdict");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[11:8] == 4'd0))
      else $error("payload result carries verdict fields");

endmodule
